// ----- design/ggrf_pkg.sv -----
// ----------------------------------------------------------------------------
// ggrf_pkg
// Shared types and constants of the grid ground removal filter.
// ----------------------------------------------------------------------------
package ggrf_pkg;

  localparam int unsigned MaxPointsDef = 4096;
  localparam int unsigned MaxRowsDef   = 64;
  localparam int unsigned MaxColsDef   = 64;

  // numerator and divisor widths of the shared divider
  localparam int unsigned NumW = 23;
  localparam int unsigned DivW = 15;

  localparam int unsigned EdgeGuardMm = 400;

  localparam logic [1:0] CmdClear = 2'd0;
  localparam logic [1:0] CmdLoad  = 2'd1;

  localparam logic [2:0] StStored  = 3'd0;
  localparam logic [2:0] StOutside = 3'd1;
  localparam logic [2:0] StFull    = 3'd2;
  localparam logic [2:0] StFetch   = 3'd3;
  localparam logic [2:0] StCleared = 3'd4;

  localparam logic [2:0] RegCellSize = 3'd0;
  localparam logic [2:0] RegRows     = 3'd1;
  localparam logic [2:0] RegCols     = 3'd2;
  localparam logic [2:0] RegLeft     = 3'd3;
  localparam logic [2:0] RegRight    = 3'd4;
  localparam logic [2:0] RegMargin   = 3'd5;
  localparam logic [2:0] RegSpan     = 3'd6;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_DIV,
    S_CHK,
    S_CELL_UPD,
    S_F_CELL,
    S_F_CELLW,
    S_F_PT
  } state_e;

endpackage

// ----- design/grid_ground_removal_filter.sv -----
// ----------------------------------------------------------------------------
// grid_ground_removal_filter
// Bins lidar points into a grid of square cells, keeps per-cell point lists and
// minimum height, and returns the indices of points inside the height band above it.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; every command gives
// exactly one result word, shown for one cycle with out_valid_o, and the
// receiver cannot stall. In a load, one shared restoring divider works out
// the row and then the column one quotient bit per cycle. A fetch spends
// S_F_CELL and S_F_CELLW on each cell it visits and S_F_PT on each point it
// inspects, bounded by the single read port of the cell and point memories.
// A clear sweeps the cell occupancy memory, one cell a cycle; the same
// sweep runs after reset, with busy high. A load into a full store answers
// at once.
module grid_ground_removal_filter
  import ggrf_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MaxPointsDef,
  parameter int unsigned MAX_ROWS   = MaxRowsDef,
  parameter int unsigned MAX_COLS   = MaxColsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd_i,
  input  logic signed [17:0] x_mm_i,
  input  logic signed [17:0] y_mm_i,
  input  logic signed [17:0] z_mm_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [17:0]        cfg_data_i,
  output logic               out_valid_o,
  output logic [2:0]         status_o,
  output logic [11:0]        point_index_o,
  output logic               index_valid_o,
  output logic               done_res_o
);

  localparam int unsigned NCells = MAX_ROWS * MAX_COLS;
  localparam int unsigned PW     = $clog2(MAX_POINTS);
  localparam int unsigned CW     = (NCells > 1) ? $clog2(NCells) : 1;
  localparam int unsigned CntW   = $clog2(NumW + 1);
  localparam int unsigned CmW    = 2 * PW + 18;
  localparam logic [PW:0] NullLink = (PW + 1)'(MAX_POINTS);

  // configuration
  logic [13:0]        cs_q;
  logic [6:0]         rows_q, cols_q;
  logic signed [17:0] left_q, right_q;
  logic [12:0]        margin_q;
  logic [13:0]        span_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q     <= 14'd200;
      rows_q   <= 7'd64;
      cols_q   <= 7'd64;
      left_q   <= 18'sd2000;
      right_q  <= -18'sd2000;
      margin_q <= 13'd140;
      span_q   <= 14'd1600;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegCellSize: cs_q     <= cfg_data_i[13:0];
        RegRows:     rows_q   <= cfg_data_i[6:0];
        RegCols:     cols_q   <= cfg_data_i[6:0];
        RegLeft:     left_q   <= cfg_data_i;
        RegRight:    right_q  <= cfg_data_i;
        RegMargin:   margin_q <= cfg_data_i[12:0];
        RegSpan:     span_q   <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  logic [13:0] g;
  logic [8:0]  rows_c, cols_c;
  assign g      = (cs_q == 14'd0) ? 14'd1 : cs_q;
  assign rows_c = ({2'b0, rows_q} > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : {2'b0, rows_q};
  assign cols_c = ({2'b0, cols_q} > 9'(MAX_COLS)) ? 9'(MAX_COLS) : {2'b0, cols_q};

  // control and datapath registers
  state_e          state_q, state_d;
  logic [CW:0]     clr_q, clr_d;
  logic            clr_rep_q, clr_rep_d;
  logic [PW:0]     count_q, count_d;
  logic [CW:0]     fcell_q, fcell_d;
  logic [PW:0]     fpt_q, fpt_d;
  logic [PW-1:0]   idx_q, idx_d;
  logic [PW-1:0]   p_q, p_d;
  logic [PW-1:0]   ftail_q, ftail_d;
  logic signed [17:0] fmin_q, fmin_d;
  logic signed [17:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [NumW-1:0] prod_q, prod_d;
  logic [NumW-1:0] quo_q, quo_d, r_q, r_d;
  logic [DivW-1:0] rem_q, rem_d, dv_q, dv_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            phase_q, phase_d;
  logic            neg_q, neg_d;
  logic [CW-1:0]   cell_q, cell_d;

  logic            ov_q, ov_d;
  logic [2:0]      st_q, st_d;
  logic [11:0]     oi_q, oi_d;
  logic            iv_q, iv_d;
  logic            dn_q, dn_d;

  // memories
  logic [35:0]   pmem [MAX_POINTS];
  logic [PW:0]   lmem [MAX_POINTS];
  logic [CmW-1:0] cmem [NCells];
  logic          omem [NCells];

  logic          pm_we, lk_we, cm_we, oc_we;
  logic [PW-1:0] pm_wa, lk_wa, pt_ra;
  logic [35:0]   pm_wd, pm_rd;
  logic [PW:0]   lk_wd, lk_rd;
  logic [CW-1:0] c_wa, c_ra;
  logic [CmW-1:0] cm_wd, cm_rd;
  logic          oc_wd, oc_rd;

  always_ff @(posedge clk_i) begin
    if (pm_we) pmem[pm_wa] <= pm_wd;
    pm_rd <= pmem[pt_ra];
  end

  always_ff @(posedge clk_i) begin
    if (lk_we) lmem[lk_wa] <= lk_wd;
    lk_rd <= lmem[pt_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cm_we) cmem[c_wa] <= cm_wd;
    cm_rd <= cmem[c_ra];
  end

  always_ff @(posedge clk_i) begin
    if (oc_we) omem[c_wa] <= oc_wd;
    oc_rd <= omem[c_ra];
  end

  // divider step
  logic [DivW:0]   tr;
  logic [DivW+1:0] sub;
  logic [NumW-1:0] quo_n;
  logic [DivW-1:0] rem_n;
  assign tr    = {rem_q, quo_q[NumW-1]};
  assign sub   = {1'b0, tr} - {2'b0, dv_q};
  assign rem_n = sub[DivW+1] ? tr[DivW-1:0] : sub[DivW-1:0];
  assign quo_n = {quo_q[NumW-2:0], ~sub[DivW+1]};

  logic signed [NumW:0] num2;
  assign num2 = {{(NumW - 18){y_q[17]}}, y_q, 1'b0} + {1'b0, prod_q};

  // fetch decision on the point read out of memory
  logic signed [17:0] py, pz;
  logic signed [19:0] lo_z, hi_z, lo_y, hi_y;
  logic               kept, last;
  logic [PW:0]        nxt;
  assign py   = pm_rd[35:18];
  assign pz   = pm_rd[17:0];
  assign lo_z = 20'(fmin_q) + $signed({7'b0, margin_q});
  assign hi_z = 20'(fmin_q) + $signed({6'b0, span_q});
  assign lo_y = 20'(right_q) + 20'sd400;
  assign hi_y = 20'(left_q) - 20'sd400;
  assign kept = (20'(pz) > lo_z) && (20'(pz) < hi_z) &&
                (20'(py) > lo_y) && (20'(py) < hi_y);
  assign last = (p_q == ftail_q);
  assign nxt  = last ? NullLink : lk_rd;

  logic [31:0] idx_w, p_w;
  assign idx_w = 32'(idx_q);
  assign p_w   = 32'(p_q);

  logic out_grid;
  assign out_grid = neg_q || (r_q >= NumW'(rows_c)) || (quo_q >= NumW'(cols_c));

  logic [CW-1:0] cell_calc;
  assign cell_calc = CW'(r_q[CW-1:0] * CW'(MAX_COLS)) + quo_q[CW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      clr_rep_q <= 1'b0;
      count_q   <= '0;
      fcell_q   <= '0;
      fpt_q     <= NullLink;
      cnt_q     <= '0;
      phase_q   <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      clr_rep_q <= clr_rep_d;
      count_q   <= count_d;
      fcell_q   <= fcell_d;
      fpt_q     <= fpt_d;
      cnt_q     <= cnt_d;
      phase_q   <= phase_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    p_q     <= p_d;
    ftail_q <= ftail_d;
    fmin_q  <= fmin_d;
    x_q     <= x_d;
    y_q     <= y_d;
    z_q     <= z_d;
    prod_q  <= prod_d;
    quo_q   <= quo_d;
    r_q     <= r_d;
    rem_q   <= rem_d;
    dv_q    <= dv_d;
    neg_q   <= neg_d;
    cell_q  <= cell_d;
    st_q    <= st_d;
    oi_q    <= oi_d;
    iv_q    <= iv_d;
    dn_q    <= dn_d;
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    clr_rep_d = clr_rep_q;
    count_d   = count_q;
    fcell_d   = fcell_q;
    fpt_d     = fpt_q;
    idx_d     = idx_q;
    p_d       = p_q;
    ftail_d   = ftail_q;
    fmin_d    = fmin_q;
    x_d       = x_q;
    y_d       = y_q;
    z_d       = z_q;
    prod_d    = prod_q;
    quo_d     = quo_q;
    r_d       = r_q;
    rem_d     = rem_q;
    dv_d      = dv_q;
    cnt_d     = cnt_q;
    phase_d   = phase_q;
    neg_d     = neg_q;
    cell_d    = cell_q;
    ov_d      = 1'b0;
    st_d      = st_q;
    oi_d      = oi_q;
    iv_d      = iv_q;
    dn_d      = dn_q;
    pm_we = 1'b0;  pm_wa = idx_q;  pm_wd = {y_q, z_q};
    lk_we = 1'b0;  lk_wa = idx_q;  lk_wd = NullLink;
    cm_we = 1'b0;  cm_wd = {idx_q, idx_q, z_q};
    oc_we = 1'b0;  oc_wd = 1'b1;
    c_wa  = cell_q;
    c_ra  = fcell_q[CW-1:0];
    pt_ra = p_q;

    case (state_q)
      S_CLEAR: begin
        oc_we = 1'b1;
        oc_wd = 1'b0;
        c_wa  = clr_q[CW-1:0];
        clr_d = clr_q + 1'b1;
        if (clr_q[CW-1:0] == CW'(NCells - 1)) begin
          state_d = S_IDLE;
          if (clr_rep_q) begin
            ov_d = 1'b1;  st_d = StCleared;  oi_d = '0;  iv_d = 1'b0;  dn_d = 1'b0;
          end
        end
      end
      S_IDLE: begin
        if (start) begin
          if (cmd_i == CmdClear) begin
            count_d   = '0;
            fcell_d   = '0;
            fpt_d     = NullLink;
            clr_d     = '0;
            clr_rep_d = 1'b1;
            state_d   = S_CLEAR;
          end else if (cmd_i == CmdLoad) begin
            if (count_q[PW]) begin
              ov_d = 1'b1;  st_d = StFull;  oi_d = '0;  iv_d = 1'b0;  dn_d = 1'b0;
            end else begin
              idx_d   = count_q[PW-1:0];
              count_d = count_q + 1'b1;
              x_d     = x_mm_i;
              y_d     = y_mm_i;
              z_d     = z_mm_i;
              state_d = S_MUL;
            end
          end else begin
            state_d = S_F_CELL;
          end
        end
      end
      S_MUL: begin
        prod_d  = NumW'(cols_c) * NumW'(g);
        quo_d   = {{(NumW - 18){1'b0}}, x_q};
        rem_d   = '0;
        dv_d    = DivW'(g);
        neg_d   = x_q[17];
        cnt_d   = '0;
        phase_d = 1'b0;
        state_d = S_DIV;
      end
      S_DIV: begin
        quo_d = quo_n;
        rem_d = rem_n;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(NumW - 1)) begin
          cnt_d = '0;
          if (!phase_q) begin
            // row done, now the column with the centring offset
            r_d     = quo_n;
            quo_d   = num2[NumW-1:0];
            rem_d   = '0;
            dv_d    = {g, 1'b0};
            neg_d   = neg_q | num2[NumW];
            phase_d = 1'b1;
          end else begin
            state_d = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (out_grid) begin
          ov_d = 1'b1;  st_d = StOutside;  oi_d = idx_w[11:0];  iv_d = 1'b1;  dn_d = 1'b0;
          state_d = S_IDLE;
        end else begin
          pm_we   = 1'b1;
          lk_we   = 1'b1;
          c_ra    = cell_calc;
          cell_d  = cell_calc;
          state_d = S_CELL_UPD;
        end
      end
      S_CELL_UPD: begin
        cm_we = 1'b1;
        oc_we = 1'b1;
        if (oc_rd) begin
          lk_we = 1'b1;
          lk_wa = cm_rd[18 +: PW];
          lk_wd = {1'b0, idx_q};
          cm_wd = {cm_rd[CmW-1 -: PW], idx_q,
                   ($signed(z_q) < $signed(cm_rd[17:0])) ? z_q : cm_rd[17:0]};
        end
        ov_d = 1'b1;  st_d = StStored;  oi_d = idx_w[11:0];  iv_d = 1'b1;  dn_d = 1'b0;
        state_d = S_IDLE;
      end
      S_F_CELL: begin
        if (fcell_q == (CW + 1)'(NCells)) begin
          ov_d = 1'b1;  st_d = StFetch;  oi_d = '0;  iv_d = 1'b0;  dn_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_F_CELLW;
        end
      end
      S_F_CELLW: begin
        if (!oc_rd || !cm_rd[17]) begin
          fcell_d = fcell_q + 1'b1;
          fpt_d   = NullLink;
          state_d = S_F_CELL;
        end else begin
          fmin_d  = cm_rd[17:0];
          ftail_d = cm_rd[18 +: PW];
          p_d     = (fpt_q == NullLink) ? cm_rd[CmW-1 -: PW] : fpt_q[PW-1:0];
          pt_ra   = p_d;
          state_d = S_F_PT;
        end
      end
      S_F_PT: begin
        if (kept) begin
          if (nxt[PW]) begin
            fcell_d = fcell_q + 1'b1;
            fpt_d   = NullLink;
          end else begin
            fpt_d = nxt;
          end
          ov_d = 1'b1;  st_d = StFetch;  oi_d = p_w[11:0];  iv_d = 1'b1;  dn_d = 1'b0;
          state_d = S_IDLE;
        end else if (nxt[PW]) begin
          fcell_d = fcell_q + 1'b1;
          fpt_d   = NullLink;
          state_d = S_F_CELL;
        end else begin
          // walk to the next point of this cell
          p_d   = nxt[PW-1:0];
          pt_ra = nxt[PW-1:0];
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy          = (state_q != S_IDLE);
  assign out_valid_o   = ov_q;
  assign status_o      = st_q;
  assign point_index_o = oi_q;
  assign index_valid_o = iv_q;
  assign done_res_o    = dn_q;

  a_done_fetch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> status_o == StFetch && !index_valid_o)
    else $error("done without fetch reply");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= NullLink)
    else $error("point count overrun");

  a_word_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StFull |-> $past(busy))
    else $error("word without work");

  a_div_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CHK |-> $past(state_q == S_DIV) && phase_q)
    else $error("range check before column quotient");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the grid ground removal filter against a behavioral copy of its
// cell store: frames of clears, loads and fetches under several grid and
// band settings, and random idling on the command side.
// ----------------------------------------------------------------------------
module tb_top;
  import ggrf_pkg::*;

  localparam int NPts   = 4096;
  localparam int NRows  = 64;
  localparam int NCols  = 64;
  localparam int NCells = NRows * NCols;
  localparam int Limit  = 60000;

  localparam logic [1:0] CmdFetch = 2'd2;
  localparam logic [1:0] CmdAlt   = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [17:0] z;
  } word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] idx;
    logic        iv;
    logic        done;
  } reply_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         cmd_i = '0;
  logic signed [17:0] x_mm_i = '0, y_mm_i = '0, z_mm_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [17:0]        cfg_data_i = '0;
  logic               out_valid_o;
  logic [2:0]         status_o;
  logic [11:0]        point_index_o;
  logic               index_valid_o;
  logic               done_res_o;

  grid_ground_removal_filter uut (.*);

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // predictor state
  int unsigned cell_mm, rows_n, cols_n, margin_mm, span_mm;
  longint      left_mm, right_mm;
  int unsigned npts, cur_cell, cur_pt;
  int          pt_y [NPts];
  int          pt_z [NPts];
  int unsigned pt_nxt [NPts];
  bit          occ [NCells];
  int unsigned head [NCells];
  int unsigned tail [NCells];
  int          cmin [NCells];

  word_t  pending[$];
  reply_t replies[$];
  int     fails = 0, n_sent = 0, n_taken = 0, n_checked = 0, n_kept = 0;
  logic   fired = 1'b0;
  int     gap = 0, calm = 0;

  function automatic longint fdiv(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q -= 1;
    return q;
  endfunction

  function automatic void wipe_frame();
    npts = 0;
    foreach (occ[i]) occ[i] = 1'b0;
    cur_cell = 0;
    cur_pt = NPts;
  endfunction

  function automatic bit in_band(int unsigned p, longint mn);
    longint z, y;
    z = pt_z[p];
    y = pt_y[p];
    return z > mn + longint'(margin_mm) && z < mn + longint'(span_mm) &&
           y > right_mm + longint'(EdgeGuardMm) && y < left_mm - longint'(EdgeGuardMm);
  endfunction

  function automatic reply_t filter_step(word_t w);
    reply_t r;
    longint g, rw, cl, row, col;
    int unsigned id, cid, p, nx, k;
    bit last;
    r = '0;
    if (w.cmd == CmdClear) begin
      wipe_frame();
      r.status = StCleared;
    end else if (w.cmd == CmdLoad) begin
      if (npts >= NPts) begin
        r.status = StFull;
        return r;
      end
      id = npts++;
      r.idx = id[11:0];
      r.iv = 1'b1;
      g = (cell_mm == 0) ? 1 : cell_mm;
      rw = (rows_n > NRows) ? NRows : rows_n;
      cl = (cols_n > NCols) ? NCols : cols_n;
      row = fdiv(longint'(w.x), g);
      col = fdiv(2 * longint'(w.y) + cl * g, 2 * g);
      if (row < 0 || row >= rw || col < 0 || col >= cl) begin
        r.status = StOutside;
        return r;
      end
      cid = int'(row * NCols + col);
      pt_y[id] = w.y;
      pt_z[id] = w.z;
      pt_nxt[id] = NPts;
      if (!occ[cid]) begin
        occ[cid] = 1'b1;
        head[cid] = id;
        cmin[cid] = w.z;
      end else begin
        pt_nxt[tail[cid]] = id;
        if (w.z < cmin[cid]) cmin[cid] = w.z;
      end
      tail[cid] = id;
      r.status = StStored;
    end else begin
      r.status = StFetch;
      while (cur_cell < NCells) begin
        cid = cur_cell;
        if (!occ[cid] || cmin[cid] >= 0) begin
          cur_cell++;
          cur_pt = NPts;
          continue;
        end
        p = (cur_pt == NPts) ? head[cid] : cur_pt;
        for (k = 0; k < NPts && p < NPts; k++) begin
          last = (p == tail[cid]);
          nx = last ? NPts : pt_nxt[p];
          if (in_band(p, cmin[cid])) begin
            if (last || nx >= NPts) begin
              cur_cell++;
              cur_pt = NPts;
            end else begin
              cur_pt = nx;
            end
            r.idx = p[11:0];
            r.iv = 1'b1;
            return r;
          end
          if (last) break;
          p = nx;
        end
        cur_cell++;
        cur_pt = NPts;
      end
      r.done = 1'b1;
    end
    return r;
  endfunction

  // driver: new word at the falling edge, held until taken
  always @(negedge clk_i) begin
    word_t w;
    if (rst_ni && !(start && !fired)) begin
      if (gap > 0) begin
        start <= 1'b0;
        gap = gap - 1;
      end else if (pending.size() > 0) begin
        w = pending.pop_front();
        start <= 1'b1;
        cmd_i <= w.cmd;
        x_mm_i <= w.x;
        y_mm_i <= w.y;
        z_mm_i <= w.z;
        n_sent++;
        if (calm > 0) begin
          calm--;
        end else if ($urandom_range(0, 99) < 3) begin
          calm = $urandom_range(20, 80);
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: gap = 0;
            4, 5, 6, 7, 8: gap = $urandom_range(1, 4);
            default: gap = $urandom_range(10, 60);
          endcase
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: compare result words, then predict the word just taken
  always @(posedge clk_i) begin
    word_t  w;
    reply_t e;
    fired <= start && !busy;
    if (rst_ni) begin
      if (out_valid_o) begin
        n_checked++;
        if (replies.size() == 0) begin
          fails++;
          $display("%0t: unexpected result word status=%0d", $time, status_o);
        end else begin
          e = replies.pop_front();
          if (e.status !== status_o || e.idx !== point_index_o ||
              e.iv !== index_valid_o || e.done !== done_res_o) begin
            fails++;
            $display("%0t: mismatch exp status=%0d idx=%0d iv=%0d done=%0d", $time,
                     e.status, e.idx, e.iv, e.done);
            $display("%0t:          got status=%0d idx=%0d iv=%0d done=%0d", $time,
                     status_o, point_index_o, index_valid_o, done_res_o);
          end
          if (e.status == StFetch && e.iv) n_kept++;
        end
      end
      if (start && !busy) begin
        w = '{cmd_i, x_mm_i, y_mm_i, z_mm_i};
        replies.insert(replies.size(), filter_step(w));
        n_taken++;
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || out_valid_o || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= Limit) begin
      $display("%0t: watchdog expired", $time);
      $display("[grid_ground_removal_filter] ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [17:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegCellSize: cell_mm = val[13:0];
      RegRows: rows_n = val[6:0];
      RegCols: cols_n = val[6:0];
      RegLeft: left_mm = longint'($signed(val));
      RegRight: right_mm = longint'($signed(val));
      RegMargin: margin_mm = val[12:0];
      RegSpan: span_mm = val[13:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pending.size() > 0 || n_taken != n_sent || replies.size() > 0 || busy);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic void push(logic [1:0] c, longint x, longint y, longint z);
    pending.insert(pending.size(), '{c, 18'(x), 18'(y), 18'(z)});
  endfunction

  // load word inside the current grid, lateral mostly inside the band
  function automatic void push_point();
    longint g, rw, cl, x, y, z, half;
    g = (cell_mm == 0) ? 1 : cell_mm;
    rw = (rows_n == 0) ? 1 : ((rows_n > NRows) ? NRows : rows_n);
    cl = (cols_n == 0) ? 1 : ((cols_n > NCols) ? NCols : cols_n);
    x = $urandom_range(0, (rw * g > 131071) ? 131071 : rw * g - 1);
    half = cl * g / 2;
    y = longint'($urandom_range(0, cl * g - 1)) - half;
    if ($urandom_range(0, 2) != 0 && right_mm + 401 < left_mm - 401)
      y = right_mm + 401 + $urandom_range(0, left_mm - right_mm - 803);
    if (y > 131071) y = 131071;
    if (y < -131072) y = -131072;
    z = longint'($urandom_range(0, 2600)) - 600;
    push(CmdLoad, x, y, z);
  endfunction

  function automatic void push_frame(int n, int tail_fetches);
    push(CmdClear, $urandom, $urandom, $urandom);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: push_point();
        6: push(CmdLoad, $urandom, $urandom, $urandom);
        7: push(CmdFetch, $urandom, $urandom, $urandom);
        8: push(CmdAlt, $urandom, $urandom, $urandom);
        default: push($urandom, $urandom, $urandom, $urandom);
      endcase
    end
    repeat (tail_fetches) push(($urandom_range(0, 3) == 0) ? CmdAlt : CmdFetch,
                               $urandom, $urandom, $urandom);
  endfunction

  initial begin
    cell_mm = 200; rows_n = 64; cols_n = 64;
    left_mm = 2000; right_mm = -2000; margin_mm = 140; span_mm = 1600;
    wipe_frame();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed frame at reset settings
    push(CmdClear, 0, 0, 0);
    push(CmdLoad, 0, 0, -100);
    push(CmdLoad, 10, 50, 500);
    push(CmdLoad, 20, -60, 40);
    push(CmdLoad, 30, 70, 1500);
    push(CmdLoad, 40, 80, 1499);
    push(CmdLoad, -1, 0, 0);
    push(CmdLoad, 131071, 0, 0);
    push(CmdLoad, -131072, -131072, -131072);
    push(CmdLoad, 5, 131071, 131071);
    push(CmdLoad, 5, -6400, -131072);
    push(CmdLoad, 5, 1700, 131071);
    push(CmdLoad, 400, 1599, -5);
    push(CmdLoad, 410, 1599, 200);
    push(CmdFetch, 0, 0, 0);
    push(CmdFetch, 0, 0, 0);
    push(CmdAlt, 0, 0, 0);
    push(CmdFetch, 0, 0, 0);
    push(CmdLoad, 0, 10, 300);
    push(CmdLoad, 12700, 6399, -10);
    push(CmdLoad, 12790, 6300, 600);
    push(CmdFetch, 0, 0, 0);
    push(CmdFetch, 0, 0, 0);
    push(CmdFetch, 0, 0, 0);
    drain();
    repeat (3) push_frame(25, 8);
    drain();

    // smallest grid, empty height band
    write_reg(RegCellSize, 1);
    write_reg(RegRows, 1);
    write_reg(RegCols, 1);
    write_reg(RegMargin, 0);
    write_reg(RegSpan, 0);
    repeat (2) push_frame(20, 4);
    drain();

    // widest cells and band
    write_reg(RegCellSize, 10000);
    write_reg(RegRows, 64);
    write_reg(RegCols, 64);
    write_reg(RegLeft, 18'h1FFFF);
    write_reg(RegRight, 18'h20000);
    write_reg(RegMargin, 8000);
    write_reg(RegSpan, 16000);
    repeat (2) push_frame(30, 8);
    drain();

    // zero cell size, oversized grid, inverted lateral band
    write_reg(RegCellSize, 0);
    write_reg(RegRows, 127);
    write_reg(RegCols, 127);
    write_reg(RegLeft, 18'h20000);
    write_reg(RegRight, 18'h1FFFF);
    write_reg(RegMargin, 13'h1FFF);
    write_reg(RegSpan, 14'h3FFF);
    push_frame(25, 4);
    drain();

    // no rows at all
    write_reg(RegRows, 0);
    write_reg(RegCols, 5);
    push_frame(15, 3);
    drain();

    // odd sizes, narrow band
    write_reg(RegCellSize, 37);
    write_reg(RegRows, 20);
    write_reg(RegCols, 33);
    write_reg(RegLeft, 500);
    write_reg(RegRight, 18'(-700));
    write_reg(RegMargin, 50);
    write_reg(RegSpan, 900);
    repeat (4) push_frame(30, 8);
    drain();

    // back to reset settings
    write_reg(RegCellSize, 200);
    write_reg(RegRows, 64);
    write_reg(RegCols, 64);
    write_reg(RegLeft, 2000);
    write_reg(RegRight, 18'(-2000));
    write_reg(RegMargin, 140);
    write_reg(RegSpan, 1600);
    push_frame(20, 4);
    repeat (4) push(CmdFetch, 0, 0, 0);
    drain();

    $display("%0d words taken, %0d result words checked, %0d kept indices returned",
             n_taken, n_checked, n_kept);
    if (fails == 0) begin
      $display("[grid_ground_removal_filter] OK");
    end else begin
      $display("[grid_ground_removal_filter] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/ggrf_pkg.sv
design/grid_ground_removal_filter.sv
sim/tb_top.sv
